// File: src/assert_macros.svh
// Assertion helpers used by the checker file src/tobfe_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

// File: src/tobfe_pkg.sv
`default_nettype none
package tobfe_pkg;

    localparam int ORDER_SLOTS  = 64;
    localparam int SYMBOL_COUNT = 16;
    localparam int PRICE_BITS   = 32;

    localparam int SLOT_AW = $clog2(ORDER_SLOTS);
    localparam int SYM_AW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_QUOTE  = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [2:0] OUT_RESTING    = 3'd0;
    localparam logic [2:0] OUT_MARKET     = 3'd1;
    localparam logic [2:0] OUT_AGGRESSIVE = 3'd2;
    localparam logic [2:0] OUT_TRIGGERED  = 3'd3;
    localparam logic [2:0] OUT_CANCELLED  = 3'd4;
    localparam logic [2:0] OUT_MISS       = 3'd5;

    typedef struct packed {
        logic [3:0]            symbol;
        logic [PRICE_BITS-1:0] price;
        logic [31:0]           volume;
        logic                  buy;
        logic                  market;
    } t_slot_entry;

    typedef struct packed {
        logic               rd_en;
        logic [SLOT_AW-1:0] rd_addr;
        logic               wr_en;      // write entry and mark slot valid
        logic [SLOT_AW-1:0] wr_addr;
        t_slot_entry        wr_data;
        logic               clr_en;     // free one slot
        logic [SLOT_AW-1:0] clr_addr;
        logic               clr_all;
    } t_slot_req;

    typedef struct packed {
        logic        valid;
        t_slot_entry entry;
    } t_slot_rsp;

    typedef struct packed {
        logic                  rd_en;
        logic [SYM_AW-1:0]     rd_addr;
        logic                  wr_en;
        logic [SYM_AW-1:0]     wr_addr;
        logic [PRICE_BITS-1:0] wr_bid;
        logic [PRICE_BITS-1:0] wr_ask;
        logic                  clr_all;
    } t_quote_req;

    typedef struct packed {
        logic                  valid;
        logic [PRICE_BITS-1:0] bid;
        logic [PRICE_BITS-1:0] ask;
    } t_quote_rsp;

endpackage
`default_nettype wire

// File: src/tobfe_ord_if.sv
`default_nettype none
interface tobfe_ord_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [5:0]  order_slot;
    logic [3:0]  symbol;
    logic [31:0] price;
    logic [31:0] volume;
    logic        is_buy;
    logic        is_market;
    logic [31:0] bid_px;
    logic [31:0] ask_px;

    modport source (
        output valid, mode, order_slot, symbol, price, volume, is_buy, is_market,
               bid_px, ask_px,
        input  ready
    );
    modport sink (
        input  valid, mode, order_slot, symbol, price, volume, is_buy, is_market,
               bid_px, ask_px,
        output ready
    );
endinterface
`default_nettype wire

// File: src/tobfe_res_if.sv
`default_nettype none
interface tobfe_res_if;
    logic        valid;
    logic        ready;
    logic [5:0]  result_slot;
    logic [2:0]  outcome;
    logic [31:0] fill_qty;
    logic [31:0] fill_px;
    logic        last;

    modport source (
        output valid, result_slot, outcome, fill_qty, fill_px, last,
        input  ready
    );
    modport sink (
        input  valid, result_slot, outcome, fill_qty, fill_px, last,
        output ready
    );
endinterface
`default_nettype wire

// File: src/tobfe_slot_store.sv
`default_nettype none
module tobfe_slot_store import tobfe_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_slot_req i_req,
    output t_slot_rsp      o_rsp
);

    t_slot_entry            r_mem [ORDER_SLOTS];
    t_slot_entry            r_rd_entry;
    logic                   r_rd_valid;
    logic [ORDER_SLOTS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_entry <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
            if (i_req.clr_all) begin
                r_valid <= '0;
            end else begin
                if (i_req.wr_en) begin
                    r_valid[i_req.wr_addr] <= 1'b1;
                end
                if (i_req.clr_en) begin
                    r_valid[i_req.clr_addr] <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.valid = r_rd_valid;
    assign o_rsp.entry = r_rd_entry;

endmodule
`default_nettype wire

// File: src/tobfe_quote_store.sv
`default_nettype none
module tobfe_quote_store import tobfe_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_quote_req i_req,
    output t_quote_rsp      o_rsp
);

    logic [PRICE_BITS-1:0]   r_bid [SYMBOL_COUNT];
    logic [PRICE_BITS-1:0]   r_ask [SYMBOL_COUNT];
    logic [PRICE_BITS-1:0]   r_rd_bid;
    logic [PRICE_BITS-1:0]   r_rd_ask;
    logic                    r_rd_valid;
    logic [SYMBOL_COUNT-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_bid[i_req.wr_addr] <= i_req.wr_bid;
            r_ask[i_req.wr_addr] <= i_req.wr_ask;
        end
        if (i_req.rd_en) begin
            r_rd_bid <= r_bid[i_req.rd_addr];
            r_rd_ask <= r_ask[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
            if (i_req.clr_all) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rsp.valid = r_rd_valid;
    assign o_rsp.bid   = r_rd_bid;
    assign o_rsp.ask   = r_rd_ask;

endmodule
`default_nettype wire

// File: src/tobfe_ctrl.sv
`default_nettype none
module tobfe_ctrl import tobfe_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    tobfe_ord_if.sink       i_ord,
    tobfe_res_if.source     o_res,
    input  wire t_slot_rsp  i_slot_rsp,
    input  wire t_quote_rsp i_quote_rsp,
    output t_slot_req       o_slot_req,
    output t_quote_req      o_quote_req
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ADD    = 3'd1;
    localparam logic [2:0] ST_CANCEL = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // captured word
    logic [5:0]            r_slot;
    logic                  r_slot_ok;
    logic [3:0]            r_sym;
    logic [PRICE_BITS-1:0] r_price;
    logic [31:0]           r_vol;
    logic                  r_buy;
    logic                  r_mkt;
    logic [PRICE_BITS-1:0] r_bid;
    logic [PRICE_BITS-1:0] r_ask;

    logic [SLOT_AW-1:0] r_rd_idx;

    // pending trigger fill, held until we know whether it is the final one
    logic                  r_pend_v;
    logic [5:0]            r_pend_slot;
    logic [31:0]           r_pend_vol;
    logic [PRICE_BITS-1:0] r_pend_px;

    logic        r_out_v;
    logic [5:0]  r_out_slot;
    logic [2:0]  r_out_outcome;
    logic [31:0] r_out_vol;
    logic [31:0] r_out_px;
    logic        r_out_last;

    logic        accept;
    logic        out_free;
    logic        in_slot_ok;
    logic        in_sym_ok;
    logic        add_fill;
    logic [PRICE_BITS-1:0] add_px;
    t_slot_entry scan_e;
    logic        scan_hit;
    logic [PRICE_BITS-1:0] scan_px;
    logic        scan_stall;
    logic        scan_end;
    logic        cancel_hit;

    logic        load_out;
    logic [5:0]  ld_slot;
    logic [2:0]  ld_outcome;
    logic [31:0] ld_vol;
    logic [31:0] ld_px;
    logic        ld_last;
    logic        pend_load;
    logic        pend_clr;
    logic        idx_adv;

    assign i_ord.ready = (r_state == ST_IDLE);
    assign accept      = i_ord.valid && i_ord.ready;
    assign out_free    = !r_out_v || o_res.ready;
    assign in_slot_ok  = 32'(i_ord.order_slot) < 32'(ORDER_SLOTS);
    assign in_sym_ok   = 32'(i_ord.symbol) < 32'(SYMBOL_COUNT);

    assign add_px   = r_buy ? i_quote_rsp.ask : i_quote_rsp.bid;
    assign add_fill = i_quote_rsp.valid &&
                      (r_mkt || (r_buy ? (r_price >= i_quote_rsp.ask)
                                       : (r_price <= i_quote_rsp.bid)));

    assign scan_e     = i_slot_rsp.entry;
    assign scan_px    = scan_e.buy ? r_ask : r_bid;
    assign scan_hit   = i_slot_rsp.valid && !scan_e.market && (scan_e.symbol == r_sym) &&
                        (scan_e.buy ? (scan_e.price >= r_ask) : (scan_e.price <= r_bid));
    assign scan_stall = scan_hit && r_pend_v && !out_free;
    assign scan_end   = (r_rd_idx == SLOT_AW'(ORDER_SLOTS - 1));
    assign cancel_hit = r_slot_ok && i_slot_rsp.valid;

    always_comb begin
        n_state     = r_state;
        o_slot_req  = '0;
        o_quote_req = '0;
        load_out    = 1'b0;
        ld_slot     = r_slot;
        ld_outcome  = OUT_RESTING;
        ld_vol      = '0;
        ld_px       = '0;
        ld_last     = 1'b1;
        pend_load   = 1'b0;
        pend_clr    = 1'b0;
        idx_adv     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_ord.mode)
                        MODE_ADD: begin
                            if (in_slot_ok && in_sym_ok) begin
                                o_quote_req.rd_en   = 1'b1;
                                o_quote_req.rd_addr = SYM_AW'(i_ord.symbol);
                                n_state             = ST_ADD;
                            end
                        end
                        MODE_CANCEL: begin
                            o_slot_req.rd_en   = in_slot_ok;
                            o_slot_req.rd_addr = SLOT_AW'(i_ord.order_slot);
                            n_state            = ST_CANCEL;
                        end
                        MODE_QUOTE: begin
                            if (in_sym_ok) begin
                                o_quote_req.wr_en   = 1'b1;
                                o_quote_req.wr_addr = SYM_AW'(i_ord.symbol);
                                o_quote_req.wr_bid  = i_ord.bid_px[PRICE_BITS-1:0];
                                o_quote_req.wr_ask  = i_ord.ask_px[PRICE_BITS-1:0];
                                o_slot_req.rd_en    = 1'b1;
                                o_slot_req.rd_addr  = '0;
                                n_state             = ST_SCAN;
                            end
                        end
                        MODE_CLEAR: begin
                            o_slot_req.clr_all  = 1'b1;
                            o_quote_req.clr_all = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (add_fill) begin
                        ld_outcome = r_mkt ? OUT_MARKET : OUT_AGGRESSIVE;
                        ld_vol     = r_vol;
                        ld_px      = 32'(add_px);
                    end else begin
                        o_slot_req.wr_en          = 1'b1;
                        o_slot_req.wr_addr        = SLOT_AW'(r_slot);
                        o_slot_req.wr_data.symbol = r_sym;
                        o_slot_req.wr_data.price  = r_price;
                        o_slot_req.wr_data.volume = r_vol;
                        o_slot_req.wr_data.buy    = r_buy;
                        o_slot_req.wr_data.market = r_mkt;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_CANCEL: begin
                if (out_free) begin
                    load_out            = 1'b1;
                    ld_outcome          = cancel_hit ? OUT_CANCELLED : OUT_MISS;
                    o_slot_req.clr_en   = cancel_hit;
                    o_slot_req.clr_addr = SLOT_AW'(r_slot);
                    n_state             = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // read data register holds while stalled since rd_en stays low
                if (!scan_stall) begin
                    if (scan_hit) begin
                        o_slot_req.clr_en   = 1'b1;
                        o_slot_req.clr_addr = r_rd_idx;
                        pend_load           = 1'b1;
                        if (r_pend_v) begin
                            load_out   = 1'b1;
                            ld_slot    = r_pend_slot;
                            ld_outcome = OUT_TRIGGERED;
                            ld_vol     = r_pend_vol;
                            ld_px      = 32'(r_pend_px);
                            ld_last    = 1'b0;
                        end
                    end
                    if (scan_end) begin
                        n_state = ST_FLUSH;
                    end else begin
                        o_slot_req.rd_en   = 1'b1;
                        o_slot_req.rd_addr = SLOT_AW'(r_rd_idx + 1'b1);
                        idx_adv            = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    load_out   = 1'b1;
                    ld_slot    = r_pend_slot;
                    ld_outcome = OUT_TRIGGERED;
                    ld_vol     = r_pend_vol;
                    ld_px      = 32'(r_pend_px);
                    pend_clr   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
            if (pend_load) begin
                r_pend_v <= 1'b1;
            end else if (pend_clr) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot    <= i_ord.order_slot;
            r_slot_ok <= in_slot_ok;
            r_sym     <= i_ord.symbol;
            r_price   <= i_ord.price[PRICE_BITS-1:0];
            r_vol     <= i_ord.volume;
            r_buy     <= i_ord.is_buy;
            r_mkt     <= i_ord.is_market;
            r_bid     <= i_ord.bid_px[PRICE_BITS-1:0];
            r_ask     <= i_ord.ask_px[PRICE_BITS-1:0];
            r_rd_idx  <= '0;
        end else if (idx_adv) begin
            r_rd_idx <= SLOT_AW'(r_rd_idx + 1'b1);
        end
        if (pend_load) begin
            r_pend_slot <= 6'(r_rd_idx);
            r_pend_vol  <= scan_e.volume;
            r_pend_px   <= scan_px;
        end
        if (load_out) begin
            r_out_slot    <= ld_slot;
            r_out_outcome <= ld_outcome;
            r_out_vol     <= ld_vol;
            r_out_px      <= ld_px;
            r_out_last    <= ld_last;
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.result_slot = r_out_slot;
    assign o_res.outcome     = r_out_outcome;
    assign o_res.fill_qty    = r_out_vol;
    assign o_res.fill_px     = r_out_px;
    assign o_res.last        = r_out_last;

endmodule
`default_nettype wire

// File: src/top_of_book_order_fill_engine.sv
// channel   dir  modport  words
// i_ord     in   sink     order / cancel / quote / clear commands
// o_res     out  source   fill, rest and cancel reports, last flags final word per command
//
// Add and cancel: one slot or quote memory read, then decide.
// Quote update: the slot memory read port visits one slot per cycle in ascending order
// unless an output stall holds the scan, then the held report is flushed. Clear: no report.
// Synchronous active-low reset clears slot and quote valid bits; memory contents stay.
// Output stalls hold the scan only at a hit; one result waits in the output register.
`default_nettype none
module top_of_book_order_fill_engine import tobfe_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tobfe_ord_if.sink   i_ord,
    tobfe_res_if.source o_res
);

    t_slot_req  slot_req;
    t_slot_rsp  slot_rsp;
    t_quote_req quote_req;
    t_quote_rsp quote_rsp;

    tobfe_slot_store u_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (slot_req),
        .o_rsp   (slot_rsp)
    );

    tobfe_quote_store u_quote (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (quote_req),
        .o_rsp   (quote_rsp)
    );

    tobfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ord       (i_ord),
        .o_res       (o_res),
        .i_slot_rsp  (slot_rsp),
        .i_quote_rsp (quote_rsp),
        .o_slot_req  (slot_req),
        .o_quote_req (quote_req)
    );

endmodule
`default_nettype wire

// File: src/tobfe_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tobfe_checker import tobfe_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [5:0]  i_out_slot,
    input wire logic [2:0]  i_out_outcome,
    input wire logic [31:0] i_out_vol,
    input wire logic [31:0] i_out_px,
    input wire logic        i_out_last
);

    logic [73:0] out_word;
    logic        out_wait;
    logic        no_fill;

    assign out_word = {i_out_slot, i_out_outcome, i_out_vol, i_out_px, i_out_last};
    assign out_wait = i_out_valid && !i_out_ready;
    assign no_fill  = i_out_outcome inside {OUT_RESTING, OUT_CANCELLED, OUT_MISS};

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, i_out_valid)

    `CHK_NEXT(a_out_stable, i_clk, i_rst_n, out_wait, $stable(out_word))

    // a non-final word means the scan still owns the block
    `CHK_IMPLY(a_busy_mid_scan, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready)

    `CHK_IMPLY(a_mid_only_trig, i_clk, i_rst_n, i_out_valid && !i_out_last, i_out_outcome == OUT_TRIGGERED)

    `CHK_IMPLY(a_no_fill_zero, i_clk, i_rst_n, i_out_valid && no_fill, i_out_vol == 32'd0 && i_out_px == 32'd0)

endmodule

bind top_of_book_order_fill_engine tobfe_checker u_tobfe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_ord.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_slot    (o_res.result_slot),
    .i_out_outcome (o_res.outcome),
    .i_out_vol     (o_res.fill_qty),
    .i_out_px      (o_res.fill_px),
    .i_out_last    (o_res.last)
);
`default_nettype wire

// File: tb/sv/top_of_book_order_fill_engine_checker.sv
`timescale 1ns / 100ps
module top_of_book_order_fill_engine_checker import tobfe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    tobfe_ord_if i_ord,
    tobfe_res_if i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [5:0]  slot;
        logic [2:0]  outcome;
        logic [31:0] qty;
        logic [31:0] px;
        logic        last;
    } t_fill_report;

    // shadow copy of the order table and the per-symbol quotes
    logic        book_live [ORDER_SLOTS];
    logic [3:0]  book_sym  [ORDER_SLOTS];
    logic [31:0] book_px   [ORDER_SLOTS];
    logic [31:0] book_qty  [ORDER_SLOTS];
    logic        book_buy  [ORDER_SLOTS];
    logic        book_mkt  [ORDER_SLOTS];
    logic        quote_live [SYMBOL_COUNT];
    logic [31:0] quote_bid  [SYMBOL_COUNT];
    logic [31:0] quote_ask  [SYMBOL_COUNT];

    t_fill_report pending_fills[$];
    int fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic clear_book();
        for (int i = 0; i < ORDER_SLOTS; i++) book_live[i] = 1'b0;
        for (int s = 0; s < SYMBOL_COUNT; s++) begin
            quote_live[s] = 1'b0;
            quote_bid[s]  = '0;
            quote_ask[s]  = '0;
        end
    endtask

    task automatic project_fills(input logic [1:0] mode, input logic [5:0] slot,
                                 input logic [3:0] sym, input logic [31:0] px,
                                 input logic [31:0] qty, input logic buy, input logic mkt,
                                 input logic [31:0] bid, input logic [31:0] ask);
        t_fill_report r;
        bit           held;
        logic [31:0]  opp;
        r    = '0;
        held = 1'b0;
        case (mode)
            MODE_ADD: begin
                r.slot = slot;
                r.last = 1'b1;
                opp = buy ? quote_ask[sym] : quote_bid[sym];
                if (quote_live[sym] && mkt) begin
                    r.outcome = OUT_MARKET;
                    r.qty     = qty;
                    r.px      = opp;
                end else if (quote_live[sym] &&
                             (buy ? (px >= quote_ask[sym]) : (px <= quote_bid[sym]))) begin
                    r.outcome = OUT_AGGRESSIVE;
                    r.qty     = qty;
                    r.px      = opp;
                end else begin
                    // no quote or no cross: order rests, replacing whatever was there
                    book_live[slot] = 1'b1;
                    book_sym[slot]  = sym;
                    book_px[slot]   = px;
                    book_qty[slot]  = qty;
                    book_buy[slot]  = buy;
                    book_mkt[slot]  = mkt;
                    r.outcome = OUT_RESTING;
                end
                pending_fills.insert(pending_fills.size(), r);
            end
            MODE_CANCEL: begin
                r.slot    = slot;
                r.last    = 1'b1;
                r.outcome = book_live[slot] ? OUT_CANCELLED : OUT_MISS;
                book_live[slot] = 1'b0;
                pending_fills.insert(pending_fills.size(), r);
            end
            MODE_QUOTE: begin
                quote_live[sym] = 1'b1;
                quote_bid[sym]  = bid;
                quote_ask[sym]  = ask;
                for (int i = 0; i < ORDER_SLOTS; i++) begin
                    if (book_live[i] && !book_mkt[i] && book_sym[i] == sym &&
                        (book_buy[i] ? (book_px[i] >= ask) : (book_px[i] <= bid))) begin
                        if (held) pending_fills.insert(pending_fills.size(), r);
                        r.slot    = i[5:0];
                        r.outcome = OUT_TRIGGERED;
                        r.qty     = book_qty[i];
                        r.px      = book_buy[i] ? ask : bid;
                        r.last    = 1'b0;
                        held      = 1'b1;
                        book_live[i] = 1'b0;
                    end
                end
                // hold back one report so the final one gets last set
                if (held) begin
                    r.last = 1'b1;
                    pending_fills.insert(pending_fills.size(), r);
                end
            end
            default: clear_book();
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    task automatic check_report();
        t_fill_report want;
        if (pending_fills.size() == 0) begin
            fails++;
            $display("%0t: unexpected word, expected nothing, got slot %0d outcome %0d",
                     $time, i_res.result_slot, i_res.outcome);
        end else begin
            want = pending_fills.pop_front();
            compare_field("result_slot", 32'(want.slot), 32'(i_res.result_slot));
            compare_field("outcome", 32'(want.outcome), 32'(i_res.outcome));
            compare_field("fill_qty", want.qty, i_res.fill_qty);
            compare_field("fill_px", want.px, i_res.fill_px);
            compare_field("last", 32'(want.last), 32'(i_res.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_book();
            pending_fills.delete();
        end else begin
            // a result word at this edge always belongs to an earlier command
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) check_report();
            if (i_ord.valid === 1'b1 && i_ord.ready === 1'b1)
                project_fills(i_ord.mode, i_ord.order_slot, i_ord.symbol, i_ord.price,
                              i_ord.volume, i_ord.is_buy, i_ord.is_market,
                              i_ord.bid_px, i_ord.ask_px);
        end
        o_pending    <= pending_fills.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/sv/top_of_book_order_fill_engine_tb.sv
`timescale 1ns / 100ps
module top_of_book_order_fill_engine_tb import tobfe_pkg::*; ();

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  slot;
        logic [3:0]  sym;
        logic [31:0] px;
        logic [31:0] qty;
        logic        buy;
        logic        mkt;
        logic [31:0] bid;
        logic [31:0] ask;
    } t_order_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   fill_pending;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_req = 1'b0;

    tobfe_ord_if ord_ch ();
    tobfe_res_if res_ch ();

    top_of_book_order_fill_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ord   (ord_ch),
        .o_res   (res_ch)
    );

    top_of_book_order_fill_engine_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ord        (ord_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (fill_pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("top_of_book_order_fill_engine regression: fail");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [31:0] pick_tick(input int lo, input int hi);
        int r;
        r = $urandom_range(99);
        if (r < 12) return $urandom;
        if (r < 14) return 32'd0;
        if (r < 16) return 32'hFFFF_FFFF;
        return $urandom_range(hi, lo);
    endfunction

    // prices cluster around the quotes so that fills are common
    function automatic t_order_cmd random_cmd();
        t_order_cmd c;
        int r;
        r     = $urandom_range(99);
        c.mode = (r < 50) ? MODE_ADD : (r < 70) ? MODE_CANCEL :
                 (r < 97) ? MODE_QUOTE : MODE_CLEAR;
        c.slot = 6'($urandom_range(63));
        c.sym  = ($urandom_range(99) < 80) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
        c.px   = pick_tick(900, 1100);
        c.qty  = $urandom;
        c.buy  = 1'($urandom_range(1));
        c.mkt  = ($urandom_range(99) < 20);
        c.bid  = pick_tick(900, 1000);
        c.ask  = pick_tick(1000, 1100);
        return c;
    endfunction

    // called at a falling edge; leaves valid high for the next word
    task automatic send_cmd(input t_order_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            ord_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        ord_ch.mode       = c.mode;
        ord_ch.order_slot = c.slot;
        ord_ch.symbol     = c.sym;
        ord_ch.price      = c.px;
        ord_ch.volume     = c.qty;
        ord_ch.is_buy     = c.buy;
        ord_ch.is_market  = c.mkt;
        ord_ch.bid_px     = c.bid;
        ord_ch.ask_px     = c.ask;
        ord_ch.valid      = 1'b1;
        do @(posedge i_clk); while (ord_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        ord_ch.valid = 1'b0;
        while (fill_pending != 0) @(negedge i_clk);
    endtask

    initial begin
        t_order_cmd c;
        int send_pcts [4];
        int recv_pcts [4];
        send_pcts = '{0, 67, 0, 32};
        recv_pcts = '{0, 0, 67, 32};

        i_rst_n           = 1'b0;
        ord_ch.valid      = 1'b0;
        ord_ch.mode       = MODE_ADD;
        ord_ch.order_slot = '0;
        ord_ch.symbol     = '0;
        ord_ch.price      = '0;
        ord_ch.volume     = '0;
        ord_ch.is_buy     = 1'b0;
        ord_ch.is_market  = 1'b0;
        ord_ch.bid_px     = '0;
        ord_ch.ask_px     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every mode and outcome, edge prices, equality crosses
        send_cmd('{MODE_CANCEL, 6'd5, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0});
        // market order with no quote rests
        send_cmd('{MODE_ADD, 6'd0, 4'd1, 32'd0, 32'd77, 1'b1, 1'b1, 32'd0, 32'd0});
        send_cmd('{MODE_ADD, 6'd63, 4'd1, 32'd0, 32'd0, 1'b0, 1'b0, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF});
        send_cmd('{MODE_ADD, 6'd1, 4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0,
                   32'd0});
        send_cmd('{MODE_ADD, 6'd2, 4'd1, 32'd100, 32'd12, 1'b1, 1'b0, 32'd0, 32'd0});
        send_cmd('{MODE_ADD, 6'd3, 4'd1, 32'd200, 32'd13, 1'b0, 1'b0, 32'd0, 32'd0});
        // triggers slots 1 and 63, not the market order in slot 0
        send_cmd('{MODE_QUOTE, 6'd0, 4'd1, 32'd0, 32'd0, 1'b0, 1'b0, 32'd90, 32'd110});
        send_cmd('{MODE_ADD, 6'd4, 4'd1, 32'd0, 32'd40, 1'b1, 1'b1, 32'd0, 32'd0});
        send_cmd('{MODE_ADD, 6'd4, 4'd1, 32'hFFFF_FFFF, 32'd41, 1'b0, 1'b1, 32'd0, 32'd0});
        send_cmd('{MODE_ADD, 6'd5, 4'd1, 32'd110, 32'd50, 1'b1, 1'b0, 32'd0, 32'd0});
        send_cmd('{MODE_ADD, 6'd6, 4'd1, 32'd90, 32'd60, 1'b0, 1'b0, 32'd0, 32'd0});
        // replaces the order already resting in slot 2
        send_cmd('{MODE_ADD, 6'd2, 4'd1, 32'd50, 32'd70, 1'b1, 1'b0, 32'd0, 32'd0});
        send_cmd('{MODE_CANCEL, 6'd0, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0});
        send_cmd('{MODE_CANCEL, 6'd0, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0});
        send_cmd('{MODE_QUOTE, 6'd0, 4'd2, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF});
        send_cmd('{MODE_ADD, 6'd7, 4'd15, 32'h8000_0000, 32'd5, 1'b1, 1'b0, 32'd0, 32'd0});
        send_cmd('{MODE_QUOTE, 6'd63, 4'd15, 32'd0, 32'd0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0});
        send_cmd('{MODE_CLEAR, 6'd63, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_cmd('{MODE_ADD, 6'd8, 4'd1, 32'd0, 32'd9, 1'b0, 1'b1, 32'd0, 32'd0});
        send_cmd('{MODE_CANCEL, 6'd3, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0});
        send_cmd('{MODE_CANCEL, 6'd63, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0});
        send_cmd('{MODE_QUOTE, 6'd0, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0});
        send_cmd('{MODE_CANCEL, 6'd8, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0});
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            repeat (15) send_cmd(random_cmd());
            wait_drained();
        end

        // long receiver hold-off while adds keep coming, so the input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        repeat (12) begin
            c = random_cmd();
            c.mode = MODE_ADD;
            send_cmd(c);
        end
        wait_drained();

        // fill every slot on one symbol, then one quote crosses all of them
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        send_cmd('{MODE_CLEAR, 6'd0, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0});
        for (int i = 0; i < ORDER_SLOTS; i++) begin
            c = random_cmd();
            c.mode = MODE_ADD;
            c.slot = i[5:0];
            c.sym  = 4'd9;
            c.mkt  = 1'b0;
            c.buy  = ~i[0];
            c.px   = c.buy ? (32'd2000 + 32'(i)) : (32'd1500 - 32'(i));
            send_cmd(c);
        end
        send_cmd('{MODE_QUOTE, 6'd0, 4'd9, 32'd0, 32'd0, 1'b0, 1'b0, 32'd1500, 32'd2000});
        wait_drained();

        // a quote scan can still be running with nothing left to report
        repeat (200) @(negedge i_clk);
        if (fail_count == 0)
            $display("top_of_book_order_fill_engine regression: pass");
        else
            $display("top_of_book_order_fill_engine regression: fail");
        $finish;
    end

endmodule

// File: top_of_book_order_fill_engine.f
+incdir+src
src/tobfe_pkg.sv
src/tobfe_ord_if.sv
src/tobfe_res_if.sv
src/tobfe_slot_store.sv
src/tobfe_quote_store.sv
src/tobfe_ctrl.sv
src/top_of_book_order_fill_engine.sv
src/tobfe_checker.sv
tb/sv/top_of_book_order_fill_engine_checker.sv
tb/sv/top_of_book_order_fill_engine_tb.sv
